[hw/rtl/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, character codes and helpers for the comment stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

	// Most words that one input byte can produce: space, held slash, the byte
	// itself and the end marker.
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;

	localparam logic [1:0] CM_NONE  = 2'd0;
	localparam logic [1:0] CM_LINE  = 2'd1;
	localparam logic [1:0] CM_BLOCK = 2'd2;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_ESC_EOL  = 2'd1;
	localparam logic [1:0] ERR_SQ_EOL   = 2'd2;
	localparam logic [1:0] ERR_DQ_EOL   = 2'd3;

	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       eot;
		logic       run_last;
		logic [1:0] err;
	} result_t;

	typedef struct packed {
		logic       esc;
		logic       sq;
		logic       dq;
		logic       slash;
		logic [1:0] cm;
		logic       star;
		logic       sp;
		logic       ea;
	} ccs_state_t;

	function automatic result_t mk_char(input logic [7:0] ch, input logic [1:0] err);
		result_t r;
		r.ch = ch;
		r.valid = 1'b1;
		r.eot = 1'b0;
		r.run_last = 1'b0;
		r.err = err;
		return r;
	endfunction

	function automatic result_t mk_end();
		result_t r;
		r.ch = 8'h00;
		r.valid = 1'b0;
		r.eot = 1'b1;
		r.run_last = 1'b0;
		r.err = ERR_NONE;
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return (c inside {CH_NL, CH_FF});
	endfunction

endpackage

[hw/rtl/ccs_step.sv]
// ----------------------------------------------------------------------------
// ccs_step
// Next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
module ccs_step (
	input  ccs_pkg::ccs_state_t state,
	input  logic [7:0]          c,
	input  logic                last,
	output ccs_pkg::ccs_state_t state_nxt,
	output ccs_pkg::result_t    res [ccs_pkg::MAX_RES],
	output logic [ccs_pkg::RES_CNT_W-1:0] res_cnt
);
	import ccs_pkg::*;

	always_comb begin
		ccs_state_t st;
		result_t    r [MAX_RES];
		logic [RES_CNT_W-1:0] n;
		logic       done;

		st = state;
		n = '0;
		done = 1'b0;
		for (int i = 0; i < MAX_RES; i++) begin
			r[i] = '0;
		end

		// A held slash is resolved by the byte that follows it.
		if (st.slash) begin
			st.slash = 1'b0;
			if (c == CH_SLASH) begin
				st.cm = CM_LINE;
				st.sp = 1'b1;
				done = 1'b1;
			end else if (c == CH_STAR) begin
				st.cm = CM_BLOCK;
				st.star = 1'b0;
				st.sp = 1'b1;
				done = 1'b1;
			end else begin
				if (st.sp && st.ea) begin
					r[n[RES_IDX_W-1:0]] = mk_char(CH_SPACE, ERR_NONE);
					n = n + 1'b1;
				end
				r[n[RES_IDX_W-1:0]] = mk_char(CH_SLASH, ERR_NONE);
				n = n + 1'b1;
				st.ea = 1'b1;
				st.sp = 1'b0;
			end
		end

		if (!done) begin
			if (st.cm == CM_LINE) begin
				if (c == CH_NL) begin
					st.cm = CM_NONE;
					st.sp = 1'b1;
				end
			end else if (st.cm == CM_BLOCK) begin
				if (st.star && c == CH_SLASH) begin
					st.cm = CM_NONE;
					st.star = 1'b0;
					st.sp = 1'b1;
				end else begin
					st.star = (c == CH_STAR);
				end
			end else if (st.esc) begin
				st.esc = 1'b0;
				r[n[RES_IDX_W-1:0]] = mk_char(c, is_eol(c) ? ERR_ESC_EOL : ERR_NONE);
				n = n + 1'b1;
				st.ea = 1'b1;
				st.sp = 1'b0;
			end else if (c == CH_BSLASH) begin
				st.esc = 1'b1;
				r[n[RES_IDX_W-1:0]] = mk_char(c, ERR_NONE);
				n = n + 1'b1;
				st.ea = 1'b1;
				st.sp = 1'b0;
			end else if (c == CH_SQUOTE && !st.dq) begin
				st.sq = ~st.sq;
				r[n[RES_IDX_W-1:0]] = mk_char(c, ERR_NONE);
				n = n + 1'b1;
				st.ea = 1'b1;
				st.sp = 1'b0;
			end else if (c == CH_DQUOTE && !st.sq) begin
				st.dq = ~st.dq;
				r[n[RES_IDX_W-1:0]] = mk_char(c, ERR_NONE);
				n = n + 1'b1;
				st.ea = 1'b1;
				st.sp = 1'b0;
			end else if (st.sq || st.dq) begin
				// A line end inside quotes closes the quote and is flagged.
				if (is_eol(c)) begin
					r[n[RES_IDX_W-1:0]] = mk_char(c, st.sq ? ERR_SQ_EOL : ERR_DQ_EOL);
					if (st.sq) begin
						st.sq = 1'b0;
					end else begin
						st.dq = 1'b0;
					end
				end else begin
					r[n[RES_IDX_W-1:0]] = mk_char(c, ERR_NONE);
				end
				n = n + 1'b1;
				st.ea = 1'b1;
				st.sp = 1'b0;
			end else if (c == CH_SLASH) begin
				st.slash = 1'b1;
			end else if (is_ws(c)) begin
				st.sp = 1'b1;
			end else begin
				if (st.sp && st.ea) begin
					r[n[RES_IDX_W-1:0]] = mk_char(CH_SPACE, ERR_NONE);
					n = n + 1'b1;
				end
				r[n[RES_IDX_W-1:0]] = mk_char(c, ERR_NONE);
				n = n + 1'b1;
				st.ea = 1'b1;
				st.sp = 1'b0;
			end
		end

		if (last) begin
			if (st.slash) begin
				if (st.sp && st.ea) begin
					r[n[RES_IDX_W-1:0]] = mk_char(CH_SPACE, ERR_NONE);
					n = n + 1'b1;
				end
				r[n[RES_IDX_W-1:0]] = mk_char(CH_SLASH, ERR_NONE);
				n = n + 1'b1;
			end
			r[n[RES_IDX_W-1:0]] = mk_end();
			n = n + 1'b1;
			st = '0;
		end

		for (int i = 0; i < MAX_RES; i++) begin
			r[i].run_last = (n != '0) && (RES_CNT_W'(i) == n - 1'b1);
		end

		state_nxt = st;
		res = r;
		res_cnt = n;
	end

endmodule

[hw/rtl/ccs_outbuf.sv]
// ----------------------------------------------------------------------------
// ccs_outbuf
// Short result queue that drains the words of one input byte in order.
// ----------------------------------------------------------------------------
module ccs_outbuf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ccs_pkg::result_t              load_res [ccs_pkg::MAX_RES],
	input  logic [ccs_pkg::RES_CNT_W-1:0] load_cnt,
	output logic                          can_load,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ccs_pkg::result_t              head
);
	import ccs_pkg::*;

	result_t              buf_q [MAX_RES];
	logic [RES_CNT_W-1:0] rem_q;
	logic                 pop;

	assign out_valid = (rem_q != '0);
	assign pop = out_valid && !out_stall;
	// New words may enter once the last pending word leaves this cycle.
	assign can_load = (rem_q == '0) || (rem_q == RES_CNT_W'(1) && pop);
	assign head = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= load_cnt;
		end else if (pop) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_res;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

[hw/rtl/c_comment_strip_whitespace_squash.sv]
// ----------------------------------------------------------------------------
// c_comment_strip_whitespace_squash
// Strips C comments and squashes whitespace in a byte stream.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | in_char, in_last
//  out     | out_valid / out_stall| out_char, char_valid, end_of_text,
//          |                      | run_last, error_code
//
// A byte is taken into an input register, processed combinationally and its
// words (zero to four) are loaded into a four-entry queue. One input word is
// accepted per cycle while out_stall is low and each byte makes at most one
// output word; a byte that makes more stalls the next byte until the single
// output port drains the queue to its last word. Reset clears the scanner
// state and empties both stages. in_stall rises only while a byte waits for
// the queue to drain.
// ----------------------------------------------------------------------------
module c_comment_strip_whitespace_squash (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       end_of_text,
	output logic       run_last,
	output logic [1:0] error_code
);
	import ccs_pkg::*;

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	ccs_state_t           state_q;
	ccs_state_t           state_nxt;
	result_t              res [MAX_RES];
	logic [RES_CNT_W-1:0] res_cnt;
	logic                 can_load;
	logic                 process;
	result_t              head;

	assign process = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (process) begin
			state_q <= state_nxt;
		end
	end

	ccs_step u_step (
		.state     (state_q),
		.c         (char_s1),
		.last      (last_s1),
		.state_nxt (state_nxt),
		.res       (res),
		.res_cnt   (res_cnt)
	);

	ccs_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (process),
		.load_res  (res),
		.load_cnt  (res_cnt),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_char = head.ch;
	assign char_valid = head.valid;
	assign end_of_text = head.eot;
	assign run_last = head.run_last;
	assign error_code = head.err;

endmodule
